// File: rtl/kfs_pkg.sv
// ----------------------------------------------------------------------------
// kfs_pkg
// shared types, codes and constants of the keypad frequency setter
// ----------------------------------------------------------------------------
package kfs_pkg;

  localparam int unsigned FreqWidth  = 14;
  localparam int unsigned KeyWidth   = 4;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned LedWidth   = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned SumWidth   = FreqWidth + 1;

  localparam logic [FreqWidth-1:0] FreqReset  = FreqWidth'(125);
  localparam logic [FreqWidth-1:0] MinReset   = FreqWidth'(125);
  localparam logic [FreqWidth-1:0] MaxReset   = FreqWidth'(8000);
  localparam logic [FreqWidth-1:0] DisplayMax = FreqWidth'(9999);

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegMinFreq = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMaxFreq = CfgIdxW'(1);

  // key codes
  localparam logic [KeyWidth-1:0] KeyLastAdjust = KeyWidth'(7);
  localparam logic [KeyWidth-1:0] KeyFreqMode   = KeyWidth'(8);
  localparam logic [KeyWidth-1:0] KeyTestMode   = KeyWidth'(9);

  localparam logic [LedWidth-1:0] ColourOff   = LedWidth'(0);
  localparam logic [LedWidth-1:0] ColourGreen = LedWidth'(2);

  typedef enum logic {
    MODE_FREQ = 1'b0,
    MODE_TEST = 1'b1
  } mode_t;

  // what the state stage hands to the digit split
  typedef struct packed {
    mode_t                mode;
    logic [FreqWidth-1:0] freq;
  } stage_t;

  // step added by each adjust key
  function automatic logic signed [SumWidth-1:0] key_step(input logic [2:0] k);
    logic signed [SumWidth-1:0] s;
    case (k)
      3'd0:    s = SumWidth'(1000);
      3'd1:    s = -SumWidth'(1000);
      3'd2:    s = SumWidth'(100);
      3'd3:    s = -SumWidth'(100);
      3'd4:    s = SumWidth'(10);
      3'd5:    s = -SumWidth'(10);
      3'd6:    s = SumWidth'(1);
      default: s = -SumWidth'(1);
    endcase
    return s;
  endfunction

endpackage

// File: rtl/kfs_control.sv
// ----------------------------------------------------------------------------
// kfs_control
// key register, limit registers and the mode / frequency update
// ----------------------------------------------------------------------------
module kfs_control (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [kfs_pkg::KeyWidth-1:0]        key,
  input  logic                                cfg_write,
  input  logic [kfs_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [kfs_pkg::FreqWidth-1:0]       cfg_data,
  output logic                                st_valid,
  input  logic                                st_ready,
  output kfs_pkg::stage_t                     st_data
);

  logic                              key_valid;
  logic [kfs_pkg::KeyWidth-1:0]      key_q;
  logic [kfs_pkg::FreqWidth-1:0]     min_freq;
  logic [kfs_pkg::FreqWidth-1:0]     max_freq;
  kfs_pkg::mode_t                    mode;
  kfs_pkg::mode_t                    mode_next;
  logic [kfs_pkg::FreqWidth-1:0]     freq;
  logic [kfs_pkg::FreqWidth-1:0]     freq_next;
  logic signed [kfs_pkg::SumWidth-1:0] sum;
  logic                              in_range;
  logic                              key_ready;
  logic                              advance;

  assign key_ready = !key_valid || !st_valid || st_ready;
  assign in_stall  = !key_ready;
  assign advance   = key_valid && (!st_valid || st_ready);

  assign sum = $signed({1'b0, freq}) + kfs_pkg::key_step(key_q[2:0]);

  // negative, above the display or outside the limits: keep the old value
  assign in_range = !sum[kfs_pkg::SumWidth-1]
                 && (sum <= $signed({1'b0, kfs_pkg::DisplayMax}))
                 && (sum >= $signed({1'b0, min_freq}))
                 && (sum <= $signed({1'b0, max_freq}));

  always_comb begin
    mode_next = mode;
    if (key_q == kfs_pkg::KeyFreqMode) begin
      mode_next = kfs_pkg::MODE_FREQ;
    end else if (key_q == kfs_pkg::KeyTestMode) begin
      mode_next = kfs_pkg::MODE_TEST;
    end
  end

  always_comb begin
    freq_next = freq;
    if (mode == kfs_pkg::MODE_FREQ && key_q <= kfs_pkg::KeyLastAdjust && in_range) begin
      freq_next = sum[kfs_pkg::FreqWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
      st_valid  <= 1'b0;
      mode      <= kfs_pkg::MODE_FREQ;
      freq      <= kfs_pkg::FreqReset;
      min_freq  <= kfs_pkg::MinReset;
      max_freq  <= kfs_pkg::MaxReset;
    end else begin
      if (key_ready) begin
        key_valid <= in_valid;
      end
      if (advance) begin
        st_valid <= 1'b1;
        mode     <= mode_next;
        freq     <= freq_next;
      end else if (st_ready) begin
        st_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          kfs_pkg::RegMinFreq: min_freq <= cfg_data;
          kfs_pkg::RegMaxFreq: max_freq <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_ready && in_valid) begin
      key_q <= key;
    end
  end

  assign st_data.mode = mode;
  assign st_data.freq = freq;

endmodule

// File: rtl/kfs_digits.sv
// ----------------------------------------------------------------------------
// kfs_digits
// decimal split of the frequency and the result register
// ----------------------------------------------------------------------------
module kfs_digits (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               st_valid,
  output logic                               st_ready,
  input  kfs_pkg::stage_t                    st_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               mode_now,
  output logic [kfs_pkg::FreqWidth-1:0]      frequency_now,
  output logic [kfs_pkg::DigitWidth-1:0]     digit_thousands,
  output logic [kfs_pkg::DigitWidth-1:0]     digit_hundreds,
  output logic [kfs_pkg::DigitWidth-1:0]     digit_tens,
  output logic [kfs_pkg::DigitWidth-1:0]     digit_ones,
  output logic [kfs_pkg::LedWidth-1:0]       led_zero_colour,
  output logic [kfs_pkg::LedWidth-1:0]       led_one_colour
);

  // quotient stage
  logic                              q_valid;
  kfs_pkg::mode_t                    q_mode;
  logic [kfs_pkg::FreqWidth-1:0]     q_freq;
  logic [3:0]                        q_th;
  logic [6:0]                        q_hu;
  logic [9:0]                        q_te;
  logic [27:0]                       prod_th;
  logic [26:0]                       prod_hu;
  logic [26:0]                       prod_te;
  logic                              q_ready;
  logic                              o_ready;

  // remainder stage
  logic [14:0]                       prod_hu10;
  logic [17:0]                       prod_te10;
  logic [3:0]                        hu_div;
  logic [6:0]                        te_div;
  logic [6:0]                        hu_digit;
  logic [9:0]                        te_digit;
  logic [kfs_pkg::FreqWidth-1:0]     on_digit;
  logic                              test_mode;

  assign o_ready  = !out_valid || !out_stall;
  assign q_ready  = !q_valid || o_ready;
  assign st_ready = q_ready;

  // reciprocal multiplies, exact for values up to 9999
  assign prod_th = 28'(st_data.freq) * 28'd8389;
  assign prod_hu = 27'(st_data.freq) * 27'd5243;
  assign prod_te = 27'(st_data.freq) * 27'd6554;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_ready) begin
        q_valid <= st_valid;
      end
      if (o_ready) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && st_valid) begin
      q_mode <= st_data.mode;
      q_freq <= st_data.freq;
      q_th   <= prod_th[26:23];
      q_hu   <= prod_hu[25:19];
      q_te   <= prod_te[25:16];
    end
  end

  // quotient by ten of the hundreds and tens counts
  assign prod_hu10 = 15'(q_hu) * 15'd205;
  assign prod_te10 = 18'(q_te) * 18'd205;
  assign hu_div    = prod_hu10[14:11];
  assign te_div    = prod_te10[17:11];
  assign hu_digit  = q_hu - 7'(7'(hu_div) * 7'd10);
  assign te_digit  = q_te - 10'(10'(te_div) * 10'd10);
  assign on_digit  = q_freq - 14'(14'(q_te) * 14'd10);
  assign test_mode = (q_mode == kfs_pkg::MODE_TEST);

  always_ff @(posedge clk) begin
    if (o_ready && q_valid) begin
      mode_now        <= test_mode;
      frequency_now   <= q_freq;
      digit_thousands <= test_mode ? '0 : q_th;
      digit_hundreds  <= test_mode ? '0 : hu_digit[3:0];
      digit_tens      <= test_mode ? '0 : te_digit[3:0];
      digit_ones      <= test_mode ? '0 : on_digit[3:0];
      led_zero_colour <= test_mode ? kfs_pkg::ColourOff : kfs_pkg::ColourGreen;
      led_one_colour  <= test_mode ? kfs_pkg::ColourGreen : kfs_pkg::ColourOff;
    end
  end

endmodule

// File: rtl/keypad_frequency_setter.sv
// ----------------------------------------------------------------------------
// keypad_frequency_setter
// front-panel key handler: mode select, bounded frequency steps, digit display
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  input    | in_valid / in_stall       | key
//  output   | out_valid / out_stall     | mode_now, frequency_now, four digits,
//           |                           | led_zero_colour, led_one_colour
//  config   | cfg_write                 | cfg_index, cfg_data
//
//  one key request per cycle while the result is not stalled; a request passes
//  the key register, mode/frequency update (one add and limit compare), the
//  reciprocal multiplies, then the remainders into the result register.
//  synchronous reset restores mode, frequency and both limits; no clearing pass.
//  a stalled result holds every stage behind it once that stage is full.
// ----------------------------------------------------------------------------
module keypad_frequency_setter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [kfs_pkg::KeyWidth-1:0]       key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               mode_now,
  output logic [kfs_pkg::FreqWidth-1:0]      frequency_now,
  output logic [kfs_pkg::DigitWidth-1:0]     digit_thousands,
  output logic [kfs_pkg::DigitWidth-1:0]     digit_hundreds,
  output logic [kfs_pkg::DigitWidth-1:0]     digit_tens,
  output logic [kfs_pkg::DigitWidth-1:0]     digit_ones,
  output logic [kfs_pkg::LedWidth-1:0]       led_zero_colour,
  output logic [kfs_pkg::LedWidth-1:0]       led_one_colour,
  input  logic                               cfg_write,
  input  logic [kfs_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [kfs_pkg::FreqWidth-1:0]      cfg_data
);

  logic            st_valid;
  logic            st_ready;
  kfs_pkg::stage_t st_data;

  kfs_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key       (key),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .st_valid  (st_valid),
    .st_ready  (st_ready),
    .st_data   (st_data)
  );

  kfs_digits u_digits (
    .clk             (clk),
    .rst             (rst),
    .st_valid        (st_valid),
    .st_ready        (st_ready),
    .st_data         (st_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .mode_now        (mode_now),
    .frequency_now   (frequency_now),
    .digit_thousands (digit_thousands),
    .digit_hundreds  (digit_hundreds),
    .digit_tens      (digit_tens),
    .digit_ones      (digit_ones),
    .led_zero_colour (led_zero_colour),
    .led_one_colour  (led_one_colour)
  );

endmodule
